FILE: hdl/hrhp_pkg.sv
package hrhp_pkg;

  // Parse phases, also reported as the field kind of each result.
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_URI     = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  // Match trackers: a count of matched characters, or a sticky fail code.
  localparam logic [3:0] KEY_LEN  = 4'd7;
  localparam logic [3:0] KEY_FAIL = 4'd15;
  localparam logic [4:0] VER_LEN  = 5'd8;
  localparam logic [4:0] VER_FAIL = 5'd31;
  localparam logic [1:0] H2C_LEN  = 2'd3;

  // Request classes reported on the final transfer of a buffer.
  localparam logic [1:0] CLASS_OTHER  = 2'd0;
  localparam logic [1:0] CLASS_H2C    = 2'd1;
  localparam logic [1:0] CLASS_HTTP10 = 2'd2;

  // ASCII characters the parser reacts to.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h68;

  // One input byte as held in the input register.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } hrhp_item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic        store_valid;
    logic [2:0]  field_kind;
    logic [6:0]  header_number;
    logic [11:0] char_position;
    logic [7:0]  char_out;
    logic        field_closed;
    logic        head_finished;
    logic [7:0]  headers_done;
    logic [1:0]  request_class;
    logic        last_out;
  } hrhp_result_t;

  // Lower-case an ASCII letter; other bytes pass unchanged.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Characters of "upgrade", lower case.
  function automatic logic [7:0] upgrade_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h75;
      4'd1:    r = 8'h70;
      4'd2:    r = 8'h67;
      4'd3:    r = 8'h72;
      4'd4:    r = 8'h61;
      4'd5:    r = 8'h64;
      4'd6:    r = 8'h65;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Characters of "http/1.0", lower case.
  function automatic logic [7:0] version_char(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0:    r = 8'h68;
      5'd1:    r = 8'h74;
      5'd2:    r = 8'h74;
      5'd3:    r = 8'h70;
      5'd4:    r = 8'h2F;
      5'd5:    r = 8'h31;
      5'd6:    r = 8'h2E;
      5'd7:    r = 8'h30;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Characters of "h2c", case sensitive.
  function automatic logic [7:0] h2c_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h68;
      2'd1:    r = 8'h32;
      2'd2:    r = 8'h63;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/hrhp_in_stage.sv
module hrhp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               advance,
  output hrhp_pkg::hrhp_item_t item,
  output logic               item_valid
);

  logic                 vld_r;
  logic                 vld_nxt;
  hrhp_pkg::hrhp_item_t item_r;

  // The register takes a new byte when it is empty or drains this cycle.
  assign in_tready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload is captured on every accepted transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.byte_value <= in_tdata;
      item_r.last_byte  <= in_tlast;
    end
  end

  assign item       = item_r;
  assign item_valid = vld_r;

endmodule

FILE: hdl/hrhp_parse_core.sv
module hrhp_parse_core #(
  parameter int MAX_HEADERS     = 128,
  parameter int LONG_FIELD_CAP  = 4095,
  parameter int KEY_CAP         = 127,
  parameter int SHORT_FIELD_CAP = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  hrhp_pkg::hrhp_item_t   item,
  output hrhp_pkg::hrhp_result_t result
);

  localparam int CAP_A   = (LONG_FIELD_CAP > KEY_CAP) ? LONG_FIELD_CAP : KEY_CAP;
  localparam int CAP_MAX = (CAP_A > SHORT_FIELD_CAP) ? CAP_A : SHORT_FIELD_CAP;
  localparam int CC_W    = $clog2(CAP_MAX + 1);
  localparam int HC_W    = $clog2(MAX_HEADERS + 1);

  logic [2:0]      phase_r,   phase_nxt;
  logic [CC_W-1:0] cc_r,      cc_nxt;
  logic [HC_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic            skip_r,    skip_nxt;
  logic [3:0]      key_m_r,   key_m_nxt;
  logic [1:0]      h2c_p_r,   h2c_p_nxt;
  logic            h2c_in_r,  h2c_in_nxt;
  logic            upg_r,     upg_nxt;
  logic [4:0]      ver_m_r,   ver_m_nxt;

  logic [7:0]        b;
  logic              store;
  logic [HC_W-1:0]   hdr_cnt_inc;
  logic [HC_W+6:0]   hn_ext;
  logic [CC_W+11:0]  pos_ext;
  logic [HC_W+7:0]   done_ext;

  assign b           = item.byte_value;
  assign hdr_cnt_inc = hdr_cnt_r + HC_W'(1);
  assign hn_ext      = {7'd0, hdr_cnt_r};
  assign pos_ext     = {12'd0, cc_r};
  assign done_ext    = {8'd0, hdr_cnt_nxt};

  // Next parser state and the result for the byte in the input register.
  always_comb begin
    phase_nxt   = phase_r;
    cc_nxt      = cc_r;
    hdr_cnt_nxt = hdr_cnt_r;
    skip_nxt    = skip_r;
    key_m_nxt   = key_m_r;
    h2c_p_nxt   = h2c_p_r;
    h2c_in_nxt  = h2c_in_r;
    upg_nxt     = upg_r;
    ver_m_nxt   = ver_m_r;
    store       = 1'b0;
    result      = '0;

    if (phase_r != hrhp_pkg::PH_DONE) begin
      result.field_kind = phase_r;
      if (phase_r >= hrhp_pkg::PH_KEY) begin
        result.header_number = hn_ext[6:0];
      end
      unique case (phase_r)
        hrhp_pkg::PH_METHOD: begin
          if (b == hrhp_pkg::CH_SPACE) begin
            phase_nxt           = hrhp_pkg::PH_URI;
            cc_nxt              = '0;
            result.field_closed = 1'b1;
          end else if (cc_r < CC_W'(SHORT_FIELD_CAP)) begin
            store = 1'b1;
          end
        end
        hrhp_pkg::PH_URI: begin
          if (b == hrhp_pkg::CH_SPACE) begin
            phase_nxt           = hrhp_pkg::PH_VERSION;
            cc_nxt              = '0;
            result.field_closed = 1'b1;
          end else if (cc_r < CC_W'(LONG_FIELD_CAP)) begin
            store = 1'b1;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (b == hrhp_pkg::CH_CR) begin
            // A carriage return inside the version is ignored.
          end else if (b == hrhp_pkg::CH_LF) begin
            phase_nxt           = hrhp_pkg::PH_KEY;
            cc_nxt              = '0;
            result.field_closed = 1'b1;
            hdr_cnt_nxt         = '0;
            key_m_nxt           = '0;
          end else if (cc_r < CC_W'(SHORT_FIELD_CAP)) begin
            store = 1'b1;
            if (ver_m_r < hrhp_pkg::VER_LEN &&
                hrhp_pkg::fold(b) == hrhp_pkg::version_char(ver_m_r)) begin
              ver_m_nxt = ver_m_r + 5'd1;
            end else begin
              ver_m_nxt = hrhp_pkg::VER_FAIL;
            end
          end
        end
        hrhp_pkg::PH_KEY: begin
          if (b == hrhp_pkg::CH_COLON) begin
            phase_nxt           = hrhp_pkg::PH_VALUE;
            cc_nxt              = '0;
            result.field_closed = 1'b1;
            skip_nxt            = 1'b1;
            h2c_p_nxt           = '0;
            h2c_in_nxt          = 1'b0;
          end else if (b == hrhp_pkg::CH_CR) begin
            // Ignored inside a key.
          end else if (b == hrhp_pkg::CH_LF) begin
            // An empty line (or a key cut by a line feed) ends the head.
            phase_nxt = hrhp_pkg::PH_DONE;
          end else if (cc_r < CC_W'(KEY_CAP)) begin
            store = 1'b1;
            if (key_m_r < hrhp_pkg::KEY_LEN &&
                hrhp_pkg::fold(b) == hrhp_pkg::upgrade_char(key_m_r)) begin
              key_m_nxt = key_m_r + 4'd1;
            end else begin
              key_m_nxt = hrhp_pkg::KEY_FAIL;
            end
          end
        end
        hrhp_pkg::PH_VALUE: begin
          if (skip_r && b == hrhp_pkg::CH_SPACE) begin
            // Leading spaces of a value are skipped.
          end else begin
            skip_nxt = 1'b0;
            if (b == hrhp_pkg::CH_CR) begin
              // Ignored inside a value.
            end else if (b == hrhp_pkg::CH_LF) begin
              result.field_closed = 1'b1;
              if (key_m_r == hrhp_pkg::KEY_LEN && h2c_in_r) begin
                upg_nxt = 1'b1;
              end
              hdr_cnt_nxt = hdr_cnt_inc;
              if (hdr_cnt_inc >= HC_W'(MAX_HEADERS)) begin
                phase_nxt = hrhp_pkg::PH_DONE;
              end else begin
                phase_nxt = hrhp_pkg::PH_KEY;
                cc_nxt    = '0;
                key_m_nxt = '0;
              end
            end else if (cc_r < CC_W'(LONG_FIELD_CAP)) begin
              store = 1'b1;
              if (b == hrhp_pkg::h2c_char(h2c_p_r)) begin
                if (h2c_p_r + 2'd1 >= hrhp_pkg::H2C_LEN) begin
                  h2c_in_nxt = 1'b1;
                  h2c_p_nxt  = '0;
                end else begin
                  h2c_p_nxt = h2c_p_r + 2'd1;
                end
              end else begin
                h2c_p_nxt = (b == hrhp_pkg::CH_H) ? 2'd1 : 2'd0;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (store) begin
        result.store_valid   = 1'b1;
        result.char_position = pos_ext[11:0];
        result.char_out      = b;
        cc_nxt               = cc_r + CC_W'(1);
      end
    end

    // Status that follows the update of this byte.
    result.head_finished = (phase_nxt == hrhp_pkg::PH_DONE);
    result.headers_done  = (done_ext > (HC_W + 8)'(255)) ? 8'hFF : done_ext[7:0];
    result.last_out      = item.last_byte;
    if (item.last_byte) begin
      if (upg_nxt) begin
        result.request_class = hrhp_pkg::CLASS_H2C;
      end else if (ver_m_nxt == hrhp_pkg::VER_LEN) begin
        result.request_class = hrhp_pkg::CLASS_HTTP10;
      end else begin
        result.request_class = hrhp_pkg::CLASS_OTHER;
      end
    end
  end

  // Parser state advances once per processed byte; the last byte restarts it.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.last_byte)) begin
      phase_r   <= hrhp_pkg::PH_METHOD;
      cc_r      <= '0;
      hdr_cnt_r <= '0;
      skip_r    <= 1'b0;
      key_m_r   <= '0;
      h2c_p_r   <= '0;
      h2c_in_r  <= 1'b0;
      upg_r     <= 1'b0;
      ver_m_r   <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      cc_r      <= cc_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      skip_r    <= skip_nxt;
      key_m_r   <= key_m_nxt;
      h2c_p_r   <= h2c_p_nxt;
      h2c_in_r  <= h2c_in_nxt;
      upg_r     <= upg_nxt;
      ver_m_r   <= ver_m_nxt;
    end
  end

  // Once the head is finished, nothing more is stored.
  a_no_store_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == hrhp_pkg::PH_DONE |-> !result.store_valid)
    else $error("byte stored after the head finished");

  // A last byte returns the parser to the method phase with no headers.
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.last_byte |=> phase_r == hrhp_pkg::PH_METHOD && hdr_cnt_r == '0)
    else $error("parser did not restart after the last byte");

  // The header count never passes the limit.
  a_header_limit: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= HC_W'(MAX_HEADERS))
    else $error("header count beyond limit");

  // Reaching the limit by a completed header always finishes the head.
  a_limit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.last_byte && hdr_cnt_nxt == HC_W'(MAX_HEADERS)
    |=> phase_r == hrhp_pkg::PH_DONE)
    else $error("header limit did not finish the head");

endmodule

FILE: hdl/hrhp_out_stage.sv
module hrhp_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  hrhp_pkg::hrhp_result_t result,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output hrhp_pkg::hrhp_result_t held
);

  logic                   vld_r;
  logic                   vld_nxt;
  hrhp_pkg::hrhp_result_t res_r;

  // Valid stays until the result transfer completes or a new one replaces it.
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = vld_r;
  assign held       = res_r;

endmodule

FILE: hdl/http_request_head_parser_top.sv
// Path: a byte accepted into the input register passes through the parse logic into
// the output register once that register is free or drains.
// Throughput: one byte per cycle while the output is not stalled by the receiver.
// Reset: rst_n is synchronous, active low; it empties both registers and
// returns the parser to the method phase. A byte marked last also restarts the parser.
module http_request_head_parser_top #(
  parameter int MAX_HEADERS     = 128,
  parameter int LONG_FIELD_CAP  = 4095,
  parameter int KEY_CAP         = 127,
  parameter int SHORT_FIELD_CAP = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [6:0] header_number, [18:7] char_position,
                                  // [26:19] char_out, [27] field_closed,
                                  // [28] head_finished, [36:29] headers_done,
                                  // [38:37] request_class, [39] zero
  output logic [3:0]  out_tuser,  // [0] store_valid, [3:1] field_kind
  output logic        out_tlast   // last_out
);

  hrhp_pkg::hrhp_item_t   item;
  hrhp_pkg::hrhp_result_t result;
  hrhp_pkg::hrhp_result_t held;
  logic                   item_valid;
  logic                   advance;

  // A byte moves on when the output register is free or drains this cycle.
  assign advance = item_valid && (!out_tvalid || out_tready);

  hrhp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  hrhp_parse_core #(
    .MAX_HEADERS     (MAX_HEADERS),
    .LONG_FIELD_CAP  (LONG_FIELD_CAP),
    .KEY_CAP         (KEY_CAP),
    .SHORT_FIELD_CAP (SHORT_FIELD_CAP)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

  hrhp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .held       (held)
  );

  // Pack the result onto the stream.
  assign out_tdata = {1'b0, held.request_class, held.headers_done, held.head_finished,
                      held.field_closed, held.char_out, held.char_position,
                      held.header_number};
  assign out_tuser = {held.field_kind, held.store_valid};
  assign out_tlast = held.last_out;

endmodule

FILE: test/tb_http_request_head_parser_top.sv
`timescale 1ns / 1ps

module tb_http_request_head_parser_top;

  localparam int MAX_HEADERS     = 128;
  localparam int LONG_FIELD_CAP  = 4095;
  localparam int KEY_CAP         = 127;
  localparam int SHORT_FIELD_CAP = 15;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 100;

  // Shapes of generated request heads.
  localparam int SHAPE_PLAIN        = 0;
  localparam int SHAPE_MANY_HEADERS = 1;
  localparam int SHAPE_LONG_KEY     = 2;

  // Patterns the classifier looks for, first character in the top byte.
  localparam logic [55:0] UPGRADE_LC = "upgrade";
  localparam logic [63:0] VERSION_LC = "http/1.0";
  localparam logic [23:0] H2C_TEXT   = "h2c";

  typedef struct {
    logic [7:0]             value;
    logic                   last;
    logic                   literal;
    hrhp_pkg::hrhp_result_t want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  // Expected results, oldest first, and the run's bookkeeping.
  hrhp_pkg::hrhp_result_t expected_results[$];
  stim_row_t              dir_table[$];
  logic [7:0]             head_bytes[$];
  int                     error_count     = 0;
  int                     results_checked = 0;
  int                     bytes_sent      = 0;
  int                     buffers_sent    = 0;
  int                     h2c_count       = 0;
  int                     http10_count    = 0;
  int                     cycle_count     = 0;
  int                     idle_pct        = 0;
  int                     stall_pct       = 0;

  // Parser state as the predictor sees it.
  logic [2:0]  parse_state;
  logic [11:0] field_len;
  logic [7:0]  hdr_total;
  logic        skip_spaces;
  logic [3:0]  key_progress;
  logic [1:0]  h2c_progress;
  logic        h2c_found;
  logic        upgrade_found;
  logic [4:0]  version_progress;

  http_request_head_parser_top #(
    .MAX_HEADERS    (MAX_HEADERS),
    .LONG_FIELD_CAP (LONG_FIELD_CAP),
    .KEY_CAP        (KEY_CAP),
    .SHORT_FIELD_CAP(SHORT_FIELD_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] byte_value
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [6:0] header_number, [18:7] char_position,
                             // [26:19] char_out, [27] field_closed,
                             // [28] head_finished, [36:29] headers_done,
                             // [38:37] request_class, [39] zero
    .out_tuser (out_tuser),  // [0] store_valid, [3:1] field_kind
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle counter that ends a run that has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending.",
               cycle_count, expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void clear_parse_state();
    parse_state      = hrhp_pkg::PH_METHOD;
    field_len        = '0;
    hdr_total        = '0;
    skip_spaces      = 1'b0;
    key_progress     = '0;
    h2c_progress     = '0;
    h2c_found        = 1'b0;
    upgrade_found    = 1'b0;
    version_progress = '0;
  endfunction

  // Works out the result of one byte and advances the parser state.
  function automatic hrhp_pkg::hrhp_result_t predict_head_byte(input logic [7:0] value,
                                                               input logic last);
    hrhp_pkg::hrhp_result_t r;
    logic                   keep;
    r    = '0;
    keep = 1'b0;
    if (parse_state != hrhp_pkg::PH_DONE) begin
      r.field_kind    = parse_state;
      r.header_number = (parse_state >= hrhp_pkg::PH_KEY) ? hdr_total[6:0] : 7'd0;
      case (parse_state)
        hrhp_pkg::PH_METHOD: begin
          if (value == hrhp_pkg::CH_SPACE) begin
            parse_state    = hrhp_pkg::PH_URI;
            field_len      = '0;
            r.field_closed = 1'b1;
          end else if (field_len < SHORT_FIELD_CAP) begin
            keep = 1'b1;
          end
        end
        hrhp_pkg::PH_URI: begin
          if (value == hrhp_pkg::CH_SPACE) begin
            parse_state    = hrhp_pkg::PH_VERSION;
            field_len      = '0;
            r.field_closed = 1'b1;
          end else if (field_len < LONG_FIELD_CAP) begin
            keep = 1'b1;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (value == hrhp_pkg::CH_CR) begin
            // Carriage returns are dropped here.
          end else if (value == hrhp_pkg::CH_LF) begin
            parse_state    = hrhp_pkg::PH_KEY;
            field_len      = '0;
            r.field_closed = 1'b1;
            hdr_total      = '0;
            key_progress   = '0;
          end else if (field_len < SHORT_FIELD_CAP) begin
            keep = 1'b1;
            if (version_progress < hrhp_pkg::VER_LEN &&
                to_lower(value) == VERSION_LC[8*(7-version_progress) +: 8]) begin
              version_progress = version_progress + 5'd1;
            end else begin
              version_progress = hrhp_pkg::VER_FAIL;
            end
          end
        end
        hrhp_pkg::PH_KEY: begin
          if (value == hrhp_pkg::CH_COLON) begin
            parse_state    = hrhp_pkg::PH_VALUE;
            field_len      = '0;
            r.field_closed = 1'b1;
            skip_spaces    = 1'b1;
            h2c_progress   = '0;
            h2c_found      = 1'b0;
          end else if (value == hrhp_pkg::CH_CR) begin
            // Carriage returns are dropped here.
          end else if (value == hrhp_pkg::CH_LF) begin
            // An empty line, or a key cut by a line feed, ends the head.
            parse_state = hrhp_pkg::PH_DONE;
          end else if (field_len < KEY_CAP) begin
            keep = 1'b1;
            if (key_progress < hrhp_pkg::KEY_LEN &&
                to_lower(value) == UPGRADE_LC[8*(6-key_progress) +: 8]) begin
              key_progress = key_progress + 4'd1;
            end else begin
              key_progress = hrhp_pkg::KEY_FAIL;
            end
          end
        end
        default: begin
          if (!(skip_spaces && value == hrhp_pkg::CH_SPACE)) begin
            skip_spaces = 1'b0;
            if (value == hrhp_pkg::CH_CR) begin
              // Carriage returns are dropped here.
            end else if (value == hrhp_pkg::CH_LF) begin
              r.field_closed = 1'b1;
              if (key_progress == hrhp_pkg::KEY_LEN && h2c_found) begin
                upgrade_found = 1'b1;
              end
              hdr_total = hdr_total + 8'd1;
              if (hdr_total >= MAX_HEADERS) begin
                parse_state = hrhp_pkg::PH_DONE;
              end else begin
                parse_state  = hrhp_pkg::PH_KEY;
                field_len    = '0;
                key_progress = '0;
              end
            end else if (field_len < LONG_FIELD_CAP) begin
              keep = 1'b1;
              if (value == H2C_TEXT[8*(2-h2c_progress) +: 8]) begin
                h2c_progress = h2c_progress + 2'd1;
                if (h2c_progress >= hrhp_pkg::H2C_LEN) begin
                  h2c_found    = 1'b1;
                  h2c_progress = '0;
                end
              end else begin
                h2c_progress = (value == hrhp_pkg::CH_H) ? 2'd1 : 2'd0;
              end
            end
          end
        end
      endcase
      if (keep) begin
        r.store_valid   = 1'b1;
        r.char_position = field_len;
        r.char_out      = value;
        field_len       = field_len + 12'd1;
      end
    end
    if (last) begin
      if (upgrade_found) begin
        r.request_class = hrhp_pkg::CLASS_H2C;
      end else if (version_progress == hrhp_pkg::VER_LEN) begin
        r.request_class = hrhp_pkg::CLASS_HTTP10;
      end else begin
        r.request_class = hrhp_pkg::CLASS_OTHER;
      end
    end
    r.head_finished = (parse_state == hrhp_pkg::PH_DONE);
    r.headers_done  = hdr_total;
    r.last_out      = last;
    if (last) begin
      clear_parse_state();
    end
    return r;
  endfunction

  function automatic hrhp_pkg::hrhp_result_t mk_result(
    input logic sv, input logic [2:0] kind, input logic [6:0] hn,
    input logic [11:0] pos, input logic [7:0] co, input logic fc,
    input logic hf, input logic [7:0] hd, input logic [1:0] cls, input logic lst);
    hrhp_pkg::hrhp_result_t r;
    r.store_valid   = sv;
    r.field_kind    = kind;
    r.header_number = hn;
    r.char_position = pos;
    r.char_out      = co;
    r.field_closed  = fc;
    r.head_finished = hf;
    r.headers_done  = hd;
    r.request_class = cls;
    r.last_out      = lst;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] value, input logic last,
                                  input logic literal, input hrhp_pkg::hrhp_result_t want);
    stim_row_t row;
    row.value   = value;
    row.last    = last;
    row.literal = literal;
    row.want    = want;
    dir_table.push_back(row);
  endfunction

  // Sends one byte, waits for its transfer and records what it must produce.
  task automatic send_byte(input logic [7:0] value, input logic last,
                           input logic literal, input hrhp_pkg::hrhp_result_t want);
    hrhp_pkg::hrhp_result_t pred;
    pred = predict_head_byte(value, last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    expected_results.push_back(literal ? want : pred);
    bytes_sent++;
    if (last && pred.request_class == hrhp_pkg::CLASS_H2C) h2c_count++;
    if (last && pred.request_class == hrhp_pkg::CLASS_HTTP10) http10_count++;
  endtask

  task automatic send_buffer();
    for (int k = 0; k < head_bytes.size(); k++) begin
      send_byte(head_bytes[k], k == head_bytes.size() - 1, 1'b0, '0);
    end
    buffers_sent++;
  endtask

  // Flips the case of letters at random.
  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if ($urandom_range(1) == 1) begin
      if (c >= "a" && c <= "z") return c - 8'd32;
      if (c >= "A" && c <= "Z") return c + 8'd32;
    end
    return c;
  endfunction

  function automatic void add_text(input string s, input bit mixed);
    for (int k = 0; k < s.len(); k++) begin
      head_bytes.push_back(mixed ? mix_case(s[k]) : s[k]);
    end
  endfunction

  function automatic void add_random(input int n, input int lo, input int hi);
    for (int k = 0; k < n; k++) begin
      head_bytes.push_back(8'($urandom_range(hi, lo)));
    end
  endfunction

  // A request head with random content, mostly but not always well formed.
  function automatic void build_request(input int shape);
    int n_headers;
    head_bytes.delete();
    case ($urandom_range(3))
      0:       add_text("GET", 0);
      1:       add_text("POST", 0);
      2:       add_text("PRI", 0);
      default: add_random($urandom_range(20, 1), "A", "Z");
    endcase
    head_bytes.push_back(hrhp_pkg::CH_SPACE);
    head_bytes.push_back("/");
    add_random($urandom_range(24, 0), 33, 126);
    if ($urandom_range(9) == 0) head_bytes.push_back(hrhp_pkg::CH_CR);
    head_bytes.push_back(hrhp_pkg::CH_SPACE);

    case ($urandom_range(4))
      0, 1:    add_text("HTTP/1.0", 1);
      2:       add_text("HTTP/1.1", 1);
      3: begin
        add_text("HTTP/1.0", 1);
        add_random(1, 33, 126);
      end
      default: add_random($urandom_range(18, 1), 33, 126);
    endcase
    if ($urandom_range(3) != 0) head_bytes.push_back(hrhp_pkg::CH_CR);
    head_bytes.push_back(hrhp_pkg::CH_LF);

    if (shape == SHAPE_MANY_HEADERS) begin
      n_headers = MAX_HEADERS + 2;
    end else begin
      n_headers = $urandom_range(5, (shape == SHAPE_LONG_KEY) ? 1 : 0);
    end
    for (int h = 0; h < n_headers; h++) begin
      if (shape == SHAPE_MANY_HEADERS) begin
        // Empty key and value keep the header limit cheap to reach.
        head_bytes.push_back(hrhp_pkg::CH_COLON);
        head_bytes.push_back(hrhp_pkg::CH_LF);
      end else begin
        // Key.
        if (shape == SHAPE_LONG_KEY && h == 0) begin
          add_random(KEY_CAP + 3, "a", "z");
        end else begin
          case ($urandom_range(5))
            0, 1, 2: add_text("Upgrade", 1);
            3: begin
              if ($urandom_range(1) == 1) begin
                add_text("Upgrad", 1);
              end else begin
                add_text("Upgrades", 1);
              end
            end
            default: add_random($urandom_range(10, 1), "A", "z");
          endcase
        end
        head_bytes.push_back(hrhp_pkg::CH_COLON);
        repeat ($urandom_range(3, 0)) head_bytes.push_back(hrhp_pkg::CH_SPACE);
        // Value.
        case ($urandom_range(6))
          0:       add_text("h2c", 0);
          1:       add_text("hh2c", 0);
          2:       add_text("websocket, h2c", 0);
          3:       add_text("H2C", 0);
          4:       add_text("h2", 0);
          5:       add_text("h2h2c", 0);
          default: add_random($urandom_range(12, 0), 32, 126);
        endcase
        if ($urandom_range(1) == 1) add_random($urandom_range(4, 0), 32, 126);
        if ($urandom_range(3) != 0) head_bytes.push_back(hrhp_pkg::CH_CR);
        head_bytes.push_back(hrhp_pkg::CH_LF);
      end
    end

    if ($urandom_range(4) != 0) begin
      if ($urandom_range(1) == 1) head_bytes.push_back(hrhp_pkg::CH_CR);
      head_bytes.push_back(hrhp_pkg::CH_LF);
    end
    add_random($urandom_range(3, 0), 0, 255);
  endfunction

  // Random bytes, weighted toward the characters the parser reacts to.
  function automatic void build_noise();
    int n;
    head_bytes.delete();
    n = $urandom_range(24, 1);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0:       head_bytes.push_back(hrhp_pkg::CH_SPACE);
        1:       head_bytes.push_back(hrhp_pkg::CH_CR);
        2:       head_bytes.push_back(hrhp_pkg::CH_LF);
        3:       head_bytes.push_back(hrhp_pkg::CH_COLON);
        4:       head_bytes.push_back(hrhp_pkg::CH_H);
        5:       head_bytes.push_back("2");
        6:       head_bytes.push_back("c");
        default: head_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    hrhp_pkg::hrhp_result_t got;
    hrhp_pkg::hrhp_result_t want;
    if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.store_valid   = out_tuser[0];
      got.field_kind    = out_tuser[3:1];
      got.header_number = out_tdata[6:0];
      got.char_position = out_tdata[18:7];
      got.char_out      = out_tdata[26:19];
      got.field_closed  = out_tdata[27];
      got.head_finished = out_tdata[28];
      got.headers_done  = out_tdata[36:29];
      got.request_class = out_tdata[38:37];
      got.last_out      = out_tlast;
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, data %h user %h last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("store_valid", want.store_valid, got.store_valid);
        check_field("field_kind", want.field_kind, got.field_kind);
        check_field("header_number", want.header_number, got.header_number);
        check_field("char_position", want.char_position, got.char_position);
        check_field("char_out", want.char_out, got.char_out);
        check_field("field_closed", want.field_closed, got.field_closed);
        check_field("head_finished", want.head_finished, got.head_finished);
        check_field("headers_done", want.headers_done, got.headers_done);
        check_field("request_class", want.request_class, got.request_class);
        check_field("last_out", want.last_out, got.last_out);
        check_field("pad bit", 12'd0, {11'd0, out_tdata[39]});
        results_checked++;
      end
    end
  end

  initial begin
    int phase_start;
    bit first;

    // A head touching every field kind, with dropped CRs, skipped spaces
    // after the colon and a line feed in a key, closed by an ignored last byte.
    add_row("G", 1'b0, 1'b1, mk_result(1, hrhp_pkg::PH_METHOD, 0, 0, "G", 0, 0, 0,
                                       hrhp_pkg::CLASS_OTHER, 0));
    add_row(hrhp_pkg::CH_SPACE, 1'b0, 1'b1,
            mk_result(0, hrhp_pkg::PH_METHOD, 0, 0, 0, 1, 0, 0, hrhp_pkg::CLASS_OTHER, 0));
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_CR, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_SPACE, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_CR, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_LF, 1'b0, 1'b1,
            mk_result(0, hrhp_pkg::PH_VERSION, 0, 0, 0, 1, 0, 0, hrhp_pkg::CLASS_OTHER, 0));
    add_row("u", 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_CR, 1'b0, 1'b0, '0);
    add_row("P", 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_COLON, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_SPACE, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_SPACE, 1'b0, 1'b0, '0);
    add_row("h", 1'b0, 1'b0, '0);
    add_row("2", 1'b0, 1'b0, '0);
    add_row("c", 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_CR, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_LF, 1'b0, 1'b0, '0);
    add_row(hrhp_pkg::CH_LF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row("A", 1'b1, 1'b1, mk_result(0, 0, 0, 0, 0, 0, 1, 1, hrhp_pkg::CLASS_OTHER, 1));
    // A single zero byte that is also the last of its buffer.
    add_row(8'h00, 1'b1, 1'b1,
            mk_result(1, hrhp_pkg::PH_METHOD, 0, 0, 8'h00, 0, 0, 0,
                      hrhp_pkg::CLASS_OTHER, 1));

    clear_parse_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      send_byte(dir_table[i].value, dir_table[i].last, dir_table[i].literal,
                dir_table[i].want);
    end

    // Random heads under four pacing phases; the sender-idle phase opens with
    // a head that drives the key cap and the receiver-stall phase with one
    // that reaches the header limit.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      phase_start = bytes_sent;
      first = 1'b1;
      while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
        if (first && phase == 1) begin
          build_request(SHAPE_LONG_KEY);
        end else if (first && phase == 2) begin
          build_request(SHAPE_MANY_HEADERS);
        end else if ($urandom_range(4) == 0) begin
          build_noise();
        end else begin
          build_request(SHAPE_PLAIN);
          // Some heads are cut short by an early last byte.
          if ($urandom_range(6) == 0) begin
            head_bytes = head_bytes[0:$urandom_range(head_bytes.size() - 1, 0)];
          end
        end
        send_buffer();
        first = 1'b0;
      end
    end
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers and checked %0d results.",
             bytes_sent, buffers_sent, results_checked);
    $display("Heads classified as h2c upgrade: %0d, as HTTP/1.0: %0d; mismatches: %0d.",
             h2c_count, http10_count, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
